/* sv/mpbag_pkg.sv */
// Shared types and constants for the mixed-precision block address generator.
// Used by mpbag_table and mixed_precision_block_address_gen_core.
package mpbag_pkg;

  localparam int DEF_MAX_BLOCKS     = 32;
  localparam int DEF_MAX_BLOCK_SIZE = 64;

  localparam int ADDR_W     = 26;
  localparam int IDX_W      = 11;
  localparam int PREC_W     = 2;
  localparam int ERR_W      = 2;
  localparam int ENTRY_W    = ADDR_W + PREC_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 88;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_LIM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_LIM  = 2'd3;

  localparam logic ACT_BUILD = 1'b0;
  localparam logic ACT_PLACE = 1'b1;

  localparam logic [PREC_W-1:0] PREC_HALF   = 2'd0;
  localparam logic [PREC_W-1:0] PREC_SINGLE = 2'd1;
  localparam logic [PREC_W-1:0] PREC_DOUBLE = 2'd2;

  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ABOVE     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE     = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NO_LAYOUT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BINIT,
    ST_BUILD,
    ST_DIV,
    ST_IDX,
    ST_READ,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } tbl_ctrl_t;

endpackage

/* sv/mpbag_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nothing but its ports.
module mpbag_div #(
  parameter int DW = 11,
  parameter int SW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [SW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? diff[SW-1:0] : trial[SW-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* sv/mpbag_table.sv */
// Block layout table: one synchronous memory of {precision, offset} words.
// Depends on mpbag_pkg for the control struct and word width.
module mpbag_table #(
  parameter int DEPTH = 528,
  parameter int IW    = 10
) (
  input  logic                         clk,
  input  mpbag_pkg::tbl_ctrl_t         ctl,
  input  logic [IW-1:0]                waddr,
  input  logic [mpbag_pkg::ENTRY_W-1:0] wdata,
  input  logic [IW-1:0]                raddr,
  output logic [mpbag_pkg::ENTRY_W-1:0] rdata
);

  logic [mpbag_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [mpbag_pkg::ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/mixed_precision_block_address_gen_core.sv */
// Place item: dividers, ST_IDX, ST_READ, ST_FIN; no-layout error goes right to ST_FIN.
// Build item: ST_BINIT, then ST_BUILD with one table write per block per cycle.
// Place time is set by the bit-serial divider: one of 11 quotient bits a cycle.
// Next item is accepted in the cycle after the result registers, even if not yet taken.
// Reset (sync, active low) clears control, config and layout_ready; tables are
// left as they are and are never read before a build writes them.
module mixed_precision_block_address_gen_core #(
  parameter int MAX_BLOCKS     = mpbag_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_BLOCK_SIZE = mpbag_pkg::DEF_MAX_BLOCK_SIZE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpbag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpbag_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [10:0] row_index, [21:11] col_index, [23:22] zero
  input  logic [mpbag_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] action
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [25:0] byte_address, [27:26] precision_code, [28] mirror_valid,
  // [54:29] mirror_address, [56:55] error_code, [82:57] total_bytes, [87:83] zero
  output logic [mpbag_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int AW    = mpbag_pkg::ADDR_W;
  localparam int XW    = mpbag_pkg::IDX_W;
  localparam int CNTW  = $clog2(MAX_BLOCKS + 1);
  localparam int SW    = $clog2(MAX_BLOCK_SIZE + 1);
  localparam int DEPTH = MAX_BLOCKS * (MAX_BLOCKS + 1) / 2;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * CNTW + 2;
  localparam int EW    = 2 * SW;
  localparam int NW    = CNTW + SW;
  localparam int PADW  = mpbag_pkg::OUT_DATA_W - (3 * AW + 5);

  mpbag_pkg::state_t    state_r, state_nxt;
  mpbag_pkg::tbl_ctrl_t tbl_ctl;

  logic [5:0]    block_count_r;
  logic [6:0]    block_size_r;
  logic [6:0]    dbl_lim_r;
  logic [6:0]    sgl_lim_r;
  logic          layout_ready_r;
  logic [AW-1:0] layout_total_r;

  logic [CNTW-1:0] bc_eff;
  logic [SW-1:0]   bs_eff;
  logic [EW-1:0]   sq_r;
  logic [NW-1:0]   n_r;

  logic          in_acc;
  logic          div_start;
  logic [XW-1:0] row_r, col_r;

  logic          div_done_row, div_done_col;
  logic [XW-1:0] q_row, q_col;
  logic [SW-1:0] rem_row, rem_col;

  logic [CNTW-1:0] c_r, r_r;
  logic [IW-1:0]   bidx_r;
  logic [AW-1:0]   off_r;
  logic [CNTW-1:0] blk_gap;
  logic [1:0]      code_b;
  logic [1:0]      shamt_b;
  logic [AW-1:0]   off_sum;
  logic            last_row, last_col;

  logic [CNTW-1:0] rb, cb;
  logic [CNTW+1:0] tri_t;
  logic [PW-1:0]   tri_p;
  logic [PW-1:0]   idx_w;
  logic [1:0]      err_idx;

  logic [1:0]    err_r;
  logic          diag_r;
  logic [EW-1:0] pr_r, pm_r;
  logic [SW-1:0] ri_r, cj_r;

  logic [mpbag_pkg::ENTRY_W-1:0] rdata;
  logic [1:0]    code_p;
  logic [1:0]    shamt_p;
  logic [AW-1:0] base_p;
  logic [EW-1:0] el_p, em_p;

  logic [AW-1:0] res_addr_r, res_maddr_r, res_total_r;
  logic [1:0]    res_prec_r, res_err_r;
  logic          res_mv_r;

  logic                             out_valid_r;
  logic [mpbag_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                             out_load;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (block_count_r == '0) begin
      bc_eff = CNTW'(1);
    end else if (32'(block_count_r) > MAX_BLOCKS) begin
      bc_eff = CNTW'(MAX_BLOCKS);
    end else begin
      bc_eff = CNTW'(block_count_r);
    end
    if (block_size_r == '0) begin
      bs_eff = SW'(1);
    end else if (32'(block_size_r) > MAX_BLOCK_SIZE) begin
      bs_eff = SW'(MAX_BLOCK_SIZE);
    end else begin
      bs_eff = SW'(block_size_r);
    end
  end

  // configuration and layout status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r  <= 6'd1;
      block_size_r   <= 7'd64;
      dbl_lim_r      <= 7'd64;
      sgl_lim_r      <= 7'd0;
      layout_ready_r <= 1'b0;
      layout_total_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mpbag_pkg::CFG_BLOCK_COUNT: begin
            block_count_r  <= cfg_data[5:0];
            layout_ready_r <= 1'b0;
          end
          mpbag_pkg::CFG_BLOCK_SIZE: begin
            block_size_r   <= cfg_data;
            layout_ready_r <= 1'b0;
          end
          mpbag_pkg::CFG_DOUBLE_LIM: dbl_lim_r <= cfg_data;
          mpbag_pkg::CFG_SINGLE_LIM: sgl_lim_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == mpbag_pkg::ST_BUILD && last_row && last_col) begin
        layout_total_r <= off_sum;
        layout_ready_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= EW'(bs_eff) * EW'(bs_eff);
    n_r  <= NW'(bc_eff) * NW'(bs_eff);
  end

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpbag_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpbag_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == mpbag_pkg::ACT_BUILD) begin
            state_nxt = mpbag_pkg::ST_BINIT;
          end else if (!layout_ready_r) begin
            state_nxt = mpbag_pkg::ST_FIN;
          end else begin
            state_nxt = mpbag_pkg::ST_DIV;
          end
        end
      end
      mpbag_pkg::ST_BINIT: state_nxt = mpbag_pkg::ST_BUILD;
      mpbag_pkg::ST_BUILD: begin
        if (last_row && last_col) begin
          state_nxt = mpbag_pkg::ST_FIN;
        end
      end
      mpbag_pkg::ST_DIV: begin
        if (div_done_row) begin
          state_nxt = mpbag_pkg::ST_IDX;
        end
      end
      mpbag_pkg::ST_IDX:  state_nxt = mpbag_pkg::ST_READ;
      mpbag_pkg::ST_READ: state_nxt = mpbag_pkg::ST_FIN;
      mpbag_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = mpbag_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mpbag_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    tbl_ctl.wr_en = 1'b0;
    tbl_ctl.rd_en = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      mpbag_pkg::ST_IDLE:  in_tready     = 1'b1;
      mpbag_pkg::ST_BUILD: tbl_ctl.wr_en = 1'b1;
      mpbag_pkg::ST_IDX:   tbl_ctl.rd_en = 1'b1;
      mpbag_pkg::ST_FIN:   out_load      = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign div_start = in_acc && (in_tuser[0] == mpbag_pkg::ACT_PLACE) && layout_ready_r;

  // row and column split into block index and in-block offset
  mpbag_div #(.DW(XW), .SW(SW)) u_div_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_tdata[XW-1:0]),
    .divisor   (bs_eff),
    .done      (div_done_row),
    .quotient  (q_row),
    .remainder (rem_row)
  );

  mpbag_div #(.DW(XW), .SW(SW)) u_div_col (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_tdata[2*XW-1:XW]),
    .divisor   (bs_eff),
    .done      (div_done_col),
    .quotient  (q_col),
    .remainder (rem_col)
  );

  // layout walk
  assign blk_gap  = r_r - c_r;
  assign last_row = (r_r == bc_eff - CNTW'(1));
  assign last_col = (c_r == bc_eff - CNTW'(1));

  always_comb begin
    if (32'(blk_gap) < 32'(dbl_lim_r)) begin
      code_b = mpbag_pkg::PREC_DOUBLE;
    end else if (32'(blk_gap) < 32'(sgl_lim_r)) begin
      code_b = mpbag_pkg::PREC_SINGLE;
    end else begin
      code_b = mpbag_pkg::PREC_HALF;
    end
  end

  assign shamt_b = code_b + 2'd1;
  assign off_sum = off_r + (AW'(sq_r) << shamt_b);

  // table index of block (rb, cb): cb*(2*bc - cb + 1)/2 + rb - cb
  assign rb      = q_row[CNTW-1:0];
  assign cb      = q_col[CNTW-1:0];
  assign tri_t   = (CNTW+2)'({bc_eff, 1'b0}) - (CNTW+2)'(cb) + (CNTW+2)'(1);
  assign tri_p   = PW'(cb) * PW'(tri_t);
  assign idx_w   = (tri_p >> 1) + PW'(rb) - PW'(cb);

  always_comb begin
    if (32'(row_r) >= 32'(n_r) || 32'(col_r) >= 32'(n_r)) begin
      err_idx = mpbag_pkg::ERR_RANGE;
    end else if (col_r > row_r) begin
      err_idx = mpbag_pkg::ERR_ABOVE;
    end else begin
      err_idx = mpbag_pkg::ERR_OK;
    end
  end

  mpbag_table #(.DEPTH(DEPTH), .IW(IW)) u_table (
    .clk   (clk),
    .ctl   (tbl_ctl),
    .waddr (bidx_r),
    .wdata ({code_b, off_r}),
    .raddr (idx_w[IW-1:0]),
    .rdata (rdata)
  );

  // address assembly
  assign code_p  = (rdata[AW+1:AW] > mpbag_pkg::PREC_DOUBLE) ? mpbag_pkg::PREC_DOUBLE
                                                             : rdata[AW+1:AW];
  assign shamt_p = code_p + 2'd1;
  assign base_p  = rdata[AW-1:0];
  assign el_p    = pr_r + EW'(cj_r);
  assign em_p    = pm_r + EW'(ri_r);

  always_ff @(posedge clk) begin
    case (state_r)
      mpbag_pkg::ST_IDLE: begin
        if (in_acc) begin
          row_r       <= in_tdata[XW-1:0];
          col_r       <= in_tdata[2*XW-1:XW];
          res_addr_r  <= '0;
          res_prec_r  <= mpbag_pkg::PREC_HALF;
          res_mv_r    <= 1'b0;
          res_maddr_r <= '0;
          res_err_r   <= mpbag_pkg::ERR_NO_LAYOUT;
          res_total_r <= layout_total_r;
        end
      end
      mpbag_pkg::ST_BINIT: begin
        c_r    <= '0;
        r_r    <= '0;
        bidx_r <= '0;
        off_r  <= '0;
      end
      mpbag_pkg::ST_BUILD: begin
        off_r  <= off_sum;
        bidx_r <= bidx_r + IW'(1);
        if (last_row) begin
          c_r <= c_r + CNTW'(1);
          r_r <= c_r + CNTW'(1);
        end else begin
          r_r <= r_r + CNTW'(1);
        end
        if (last_row && last_col) begin
          res_addr_r  <= '0;
          res_prec_r  <= mpbag_pkg::PREC_HALF;
          res_mv_r    <= 1'b0;
          res_maddr_r <= '0;
          res_err_r   <= mpbag_pkg::ERR_OK;
          res_total_r <= off_sum;
        end
      end
      mpbag_pkg::ST_IDX: begin
        err_r  <= err_idx;
        diag_r <= (rb == cb);
        ri_r   <= rem_row;
        cj_r   <= rem_col;
        pr_r   <= EW'(rem_row) * EW'(bs_eff);
        pm_r   <= EW'(rem_col) * EW'(bs_eff);
      end
      mpbag_pkg::ST_READ: begin
        res_err_r   <= err_r;
        res_total_r <= layout_total_r;
        if (err_r != mpbag_pkg::ERR_OK) begin
          res_addr_r  <= '0;
          res_prec_r  <= mpbag_pkg::PREC_HALF;
          res_mv_r    <= 1'b0;
          res_maddr_r <= '0;
        end else begin
          res_addr_r  <= base_p + (AW'(el_p) << shamt_p);
          res_prec_r  <= code_p;
          res_mv_r    <= diag_r;
          res_maddr_r <= diag_r ? (base_p + (AW'(em_p) << shamt_p)) : '0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {{PADW{1'b0}}, res_total_r, res_err_r, res_maddr_r, res_mv_r,
                     res_prec_r, res_addr_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != mpbag_pkg::ST_IDLE))
    else $error("accepted word did not start work");

  a_dividers_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    div_done_row == div_done_col)
    else $error("row and column dividers out of step");

  a_write_only_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_ctl.wr_en |-> (state_r == mpbag_pkg::ST_BUILD))
    else $error("table written outside layout walk");

  a_error_clears_address: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[56:55] != mpbag_pkg::ERR_OK) |->
      (out_tdata[28:0] == '0 && out_tdata[54:29] == '0))
    else $error("error word carries an address");

  a_mirror_only_diag_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_mv_r) |-> (res_err_r == mpbag_pkg::ERR_OK))
    else $error("mirror flagged on failed placement");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for mixed_precision_block_address_gen_core: directed table, then
// random layout/place traffic with random idling, checked against an in-bench address model.
// Depends on mpbag_pkg and the core RTL only.
module tb;

  localparam int DEPTH = mpbag_pkg::DEF_MAX_BLOCKS * (mpbag_pkg::DEF_MAX_BLOCKS + 1) / 2;
  localparam int ITEMS = 1300;

  typedef logic [mpbag_pkg::ADDR_W-1:0]     addr_t;
  typedef logic [mpbag_pkg::IDX_W-1:0]      idx_t;
  typedef logic [mpbag_pkg::CFG_IDX_W-1:0]  cfgi_t;
  typedef logic [mpbag_pkg::CFG_DATA_W-1:0] cfgd_t;
  typedef logic [mpbag_pkg::PREC_W-1:0]     prec_t;
  typedef logic [mpbag_pkg::ERR_W-1:0]      err_t;

  typedef struct packed {
    addr_t addr;
    prec_t prec;
    logic  mirror;
    addr_t maddr;
    err_t  err;
    addr_t total;
  } loc_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cfgi_t     reg_idx;
    cfgd_t     reg_val;
    logic      act;
    idx_t      row;
    idx_t      col;
    logic      fixed;
    loc_t      want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  cfgi_t cfg_index;
  cfgd_t cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [mpbag_pkg::IN_DATA_W-1:0] in_tdata;
  logic [0:0] in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [mpbag_pkg::OUT_DATA_W-1:0] out_tdata;

  // register shadow and layout tables
  logic [5:0] shd_count;
  logic [6:0] shd_size;
  logic [6:0] shd_dlim;
  logic [6:0] shd_slim;
  addr_t off_tbl [DEPTH];
  prec_t prec_tbl [DEPTH];
  logic layout_ok;
  addr_t lay_total;

  loc_t loc_q [$];
  dir_row_t dir_q [$];
  int mismatches = 0;
  int sent = 0;
  int taken = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  mixed_precision_block_address_gen_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int blocks_side();
    if (shd_count < 1) return 1;
    if (shd_count > mpbag_pkg::DEF_MAX_BLOCKS) return mpbag_pkg::DEF_MAX_BLOCKS;
    return int'(shd_count);
  endfunction

  function automatic int block_edge();
    if (shd_size < 1) return 1;
    if (shd_size > mpbag_pkg::DEF_MAX_BLOCK_SIZE) return mpbag_pkg::DEF_MAX_BLOCK_SIZE;
    return int'(shd_size);
  endfunction

  function automatic void set_reg(input cfgi_t idx, input cfgd_t val);
    case (idx)
      mpbag_pkg::CFG_BLOCK_COUNT: begin
        shd_count = val[5:0];
        layout_ok = 1'b0;
      end
      mpbag_pkg::CFG_BLOCK_SIZE: begin
        shd_size = val;
        layout_ok = 1'b0;
      end
      mpbag_pkg::CFG_DOUBLE_LIM: shd_dlim = val;
      default:                   shd_slim = val;
    endcase
  endfunction

  // walk blocks column by column, top to bottom, accumulating byte offsets
  function automatic void lay_out();
    int bc, bs, idx, c, r, gap_b;
    prec_t code;
    addr_t off;
    bc = blocks_side();
    bs = block_edge();
    idx = 0;
    off = '0;
    for (c = 0; c < bc; c++) begin
      for (r = c; r < bc; r++) begin
        gap_b = r - c;
        if (gap_b < int'(shd_dlim)) code = mpbag_pkg::PREC_DOUBLE;
        else if (gap_b < int'(shd_slim)) code = mpbag_pkg::PREC_SINGLE;
        else code = mpbag_pkg::PREC_HALF;
        if (idx < DEPTH) begin
          off_tbl[idx] = off;
          prec_tbl[idx] = code;
        end
        off = addr_t'(off + (2 << code) * bs * bs);
        idx++;
      end
    end
    lay_total = off;
    layout_ok = 1'b1;
  endfunction

  function automatic loc_t locate(input logic act, input int row, input int col);
    loc_t res;
    int bc, bs, rb, ri, cb, cj, idx, bytes;
    prec_t code;
    addr_t base;
    res = '0;
    if (act == mpbag_pkg::ACT_BUILD) begin
      lay_out();
    end else if (!layout_ok) begin
      res.err = mpbag_pkg::ERR_NO_LAYOUT;
    end else begin
      bc = blocks_side();
      bs = block_edge();
      if (row >= bc * bs || col >= bc * bs) begin
        res.err = mpbag_pkg::ERR_RANGE;
      end else if (col > row) begin
        res.err = mpbag_pkg::ERR_ABOVE;
      end else begin
        rb = row / bs;
        ri = row % bs;
        cb = col / bs;
        cj = col % bs;
        idx = cb * bc - (cb * (cb - (cb > 0 ? 1 : 0))) / 2 + (rb - cb);
        if (idx >= DEPTH) idx = DEPTH - 1;
        base = off_tbl[idx];
        code = prec_tbl[idx];
        if (code > mpbag_pkg::PREC_DOUBLE) code = mpbag_pkg::PREC_DOUBLE;
        bytes = 2 << code;
        res.prec = code;
        res.addr = addr_t'(base + (ri * bs + cj) * bytes);
        if (rb == cb) begin
          res.mirror = 1'b1;
          res.maddr = addr_t'(base + (cj * bs + ri) * bytes);
        end
      end
    end
    res.total = lay_total;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic cfgd_t pick_reg(input cfgi_t idx);
    bit wide;
    wide = ($urandom_range(0, 7) == 0);
    case (idx)
      mpbag_pkg::CFG_BLOCK_COUNT:
        return cfgd_t'(wide ? $urandom_range(0, 63) : $urandom_range(1, 6));
      mpbag_pkg::CFG_BLOCK_SIZE:
        return cfgd_t'(wide ? $urandom_range(0, 127) : $urandom_range(1, 12));
      default:
        return cfgd_t'(wide ? $urandom_range(0, 127) : $urandom_range(0, 5));
    endcase
  endfunction

  function automatic void pick_place(output idx_t row, output idx_t col);
    int n, bc, bs, blk, r;
    bc = blocks_side();
    bs = block_edge();
    n = bc * bs;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      row = idx_t'($urandom);
      col = idx_t'($urandom);
    end else if (r < 18 && n > 1) begin
      col = idx_t'($urandom_range(1, n - 1));
      row = idx_t'($urandom_range(0, int'(col) - 1));
    end else if (r < 40) begin
      blk = $urandom_range(0, bc - 1);
      row = idx_t'(blk * bs + $urandom_range(0, bs - 1));
      col = idx_t'(blk * bs + $urandom_range(0, bs - 1));
    end else begin
      row = idx_t'($urandom_range(0, n - 1));
      col = idx_t'($urandom_range(0, int'(row)));
    end
  endfunction

  function automatic void t_cfg(input cfgi_t idx, input cfgd_t val);
    dir_row_t d;
    d = '0;
    d.kind = ROW_CFG;
    d.reg_idx = idx;
    d.reg_val = val;
    dir_q = {dir_q, d};
  endfunction

  function automatic void t_item(input logic act, input int row, input int col);
    dir_row_t d;
    d = '0;
    d.kind = ROW_ITEM;
    d.act = act;
    d.row = idx_t'(row);
    d.col = idx_t'(col);
    dir_q = {dir_q, d};
  endfunction

  function automatic void t_fix(input logic act, input int row, input int col, input int addr,
                                input prec_t prec, input logic mv, input int maddr,
                                input err_t err, input int total);
    dir_row_t d;
    d = '0;
    d.kind = ROW_ITEM;
    d.act = act;
    d.row = idx_t'(row);
    d.col = idx_t'(col);
    d.fixed = 1'b1;
    d.want.addr = addr_t'(addr);
    d.want.prec = prec;
    d.want.mirror = mv;
    d.want.maddr = addr_t'(maddr);
    d.want.err = err;
    d.want.total = addr_t'(total);
    dir_q = {dir_q, d};
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < 40)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input cfgi_t idx, input cfgd_t val);
    int gap;
    if (in_tvalid) in_tvalid <= 1'b0;
    while (loc_q.size() != 0) @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic send_word(input logic act, input idx_t row, input idx_t col,
                           input logic fixed, input loc_t want);
    int gap;
    loc_t model;
    if (cfg_valid) cfg_valid <= 1'b0;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, col, row};
    in_tuser <= act;
    do @(posedge clk); while (!in_tready);
    model = locate(act, int'(row), int'(col));
    if (fixed) model = want;
    loc_q = {loc_q, model};
    sent++;
    @(negedge clk);
  endtask

  // result side: random stalls, plus long hold-offs that back up the core
  initial begin
    loc_t want, got;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (loc_q.size() == 0) begin
          report("word with nothing expected", 0, 0);
        end else begin
          want = loc_q.pop_front();
          got.addr = out_tdata[25:0];
          got.prec = out_tdata[27:26];
          got.mirror = out_tdata[28];
          got.maddr = out_tdata[54:29];
          got.err = out_tdata[56:55];
          got.total = out_tdata[82:57];
          if (got.addr !== want.addr)
            report("byte_address", 32'(got.addr), 32'(want.addr));
          if (got.prec !== want.prec)
            report("precision_code", 32'(got.prec), 32'(want.prec));
          if (got.mirror !== want.mirror)
            report("mirror_valid", 32'(got.mirror), 32'(want.mirror));
          if (got.maddr !== want.maddr)
            report("mirror_address", 32'(got.maddr), 32'(want.maddr));
          if (got.err !== want.err)
            report("error_code", 32'(got.err), 32'(want.err));
          if (got.total !== want.total)
            report("total_bytes", 32'(got.total), 32'(want.total));
          taken++;
          if (taken == 150 || taken == 700) stall_left = 250;
        end
      end
    end
  end

  initial begin
    cfgi_t cfg_order [4];
    logic regrid;
    idx_t r, c;
    int len;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    shd_count = 6'd1;
    shd_size = 7'd64;
    shd_dlim = 7'd64;
    shd_slim = 7'd0;
    layout_ok = 1'b0;
    lay_total = '0;
    cfg_order = '{mpbag_pkg::CFG_BLOCK_COUNT, mpbag_pkg::CFG_BLOCK_SIZE,
                  mpbag_pkg::CFG_DOUBLE_LIM, mpbag_pkg::CFG_SINGLE_LIM};

    t_fix(mpbag_pkg::ACT_PLACE, 0, 0, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_NO_LAYOUT, 0);
    t_fix(mpbag_pkg::ACT_PLACE, 2047, 2047, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_NO_LAYOUT, 0);
    t_fix(mpbag_pkg::ACT_BUILD, 2047, 2047, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_OK, 32768);
    t_fix(mpbag_pkg::ACT_PLACE, 0, 0, 0, mpbag_pkg::PREC_DOUBLE, 1, 0,
          mpbag_pkg::ERR_OK, 32768);
    t_fix(mpbag_pkg::ACT_PLACE, 63, 0, 32256, mpbag_pkg::PREC_DOUBLE, 1, 504,
          mpbag_pkg::ERR_OK, 32768);
    t_fix(mpbag_pkg::ACT_PLACE, 0, 63, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_ABOVE, 32768);
    t_fix(mpbag_pkg::ACT_PLACE, 64, 0, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_RANGE, 32768);
    t_fix(mpbag_pkg::ACT_PLACE, 2047, 2047, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_RANGE, 32768);
    t_cfg(mpbag_pkg::CFG_BLOCK_COUNT, 0);
    t_fix(mpbag_pkg::ACT_PLACE, 0, 0, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_NO_LAYOUT, 32768);
    t_cfg(mpbag_pkg::CFG_BLOCK_COUNT, 63);
    t_cfg(mpbag_pkg::CFG_BLOCK_SIZE, 1);
    t_cfg(mpbag_pkg::CFG_DOUBLE_LIM, 0);
    t_cfg(mpbag_pkg::CFG_SINGLE_LIM, 0);
    t_fix(mpbag_pkg::ACT_BUILD, 0, 0, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_OK, 1056);
    t_item(mpbag_pkg::ACT_PLACE, 31, 0);
    t_item(mpbag_pkg::ACT_PLACE, 31, 31);
    t_fix(mpbag_pkg::ACT_PLACE, 2047, 0, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_RANGE, 1056);
    t_cfg(mpbag_pkg::CFG_BLOCK_COUNT, 32);
    t_cfg(mpbag_pkg::CFG_BLOCK_SIZE, 127);
    t_cfg(mpbag_pkg::CFG_DOUBLE_LIM, 1);
    t_cfg(mpbag_pkg::CFG_SINGLE_LIM, 3);
    t_fix(mpbag_pkg::ACT_PLACE, 0, 0, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_NO_LAYOUT, 1056);
    t_item(mpbag_pkg::ACT_BUILD, 0, 0);
    t_item(mpbag_pkg::ACT_PLACE, 2047, 0);
    t_item(mpbag_pkg::ACT_PLACE, 2047, 2047);
    t_item(mpbag_pkg::ACT_PLACE, 2047, 2046);
    t_fix(mpbag_pkg::ACT_PLACE, 2046, 2047, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_ABOVE, 5611520);
    t_cfg(mpbag_pkg::CFG_DOUBLE_LIM, 127);
    t_cfg(mpbag_pkg::CFG_SINGLE_LIM, 127);
    t_item(mpbag_pkg::ACT_PLACE, 100, 37);
    t_cfg(mpbag_pkg::CFG_BLOCK_COUNT, 2);
    t_cfg(mpbag_pkg::CFG_BLOCK_SIZE, 3);
    t_cfg(mpbag_pkg::CFG_DOUBLE_LIM, 0);
    t_cfg(mpbag_pkg::CFG_SINGLE_LIM, 1);
    t_item(mpbag_pkg::ACT_BUILD, 0, 0);
    t_item(mpbag_pkg::ACT_PLACE, 5, 0);
    t_item(mpbag_pkg::ACT_PLACE, 4, 3);
    t_fix(mpbag_pkg::ACT_PLACE, 6, 0, 0, mpbag_pkg::PREC_HALF, 0, 0,
          mpbag_pkg::ERR_RANGE, 90);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_q[k]) begin
      if (dir_q[k].kind == ROW_CFG)
        write_reg(dir_q[k].reg_idx, dir_q[k].reg_val);
      else
        send_word(dir_q[k].act, dir_q[k].row, dir_q[k].col, dir_q[k].fixed, dir_q[k].want);
    end

    while (sent < ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      regrid = 1'b0;
      foreach (cfg_order[k]) begin
        if ($urandom_range(0, 3) != 0) begin
          write_reg(cfg_order[k], pick_reg(cfg_order[k]));
          if (cfg_order[k] == mpbag_pkg::CFG_BLOCK_COUNT ||
              cfg_order[k] == mpbag_pkg::CFG_BLOCK_SIZE) regrid = 1'b1;
        end
      end
      if (regrid && $urandom_range(0, 9) != 0)
        send_word(mpbag_pkg::ACT_BUILD, idx_t'($urandom), idx_t'($urandom), 1'b0, '0);
      len = $urandom_range(40, 120);
      repeat (len) begin
        if ($urandom_range(0, 39) == 0) begin
          send_word(mpbag_pkg::ACT_BUILD, idx_t'($urandom), idx_t'($urandom), 1'b0, '0);
        end else begin
          pick_place(r, c);
          send_word(mpbag_pkg::ACT_PLACE, r, c, 1'b0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (loc_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (loc_q.size() != 0) report("words never delivered", 0, loc_q.size());
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
